### hdl/rrf_pkg.sv
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared types and codes for the receive ring FIFO.
// ----------------------------------------------------------------------------
package rrf_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int BURST_MAX_DEF = 64;

  localparam int MODE_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int REQ_W   = 7;
  localparam int STAT_W  = 2;
  localparam int LEVEL_W = 9;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BURST = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_BURST,
    OP_FLUSH,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] rx_byte;
    logic [REQ_W-1:0]  req;      // already clamped to the burst limit
  } cmd_t;

endpackage

### hdl/rrf_ram.sv
// ----------------------------------------------------------------------------
// rrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/rrf_front.sv
// ----------------------------------------------------------------------------
// rrf_front
// Input side: decodes the mode, clamps the burst request and queues the
// command in a two-entry queue toward the executor.
// ----------------------------------------------------------------------------
module rrf_front #(
  parameter int BURST_MAX = rrf_pkg::BURST_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rrf_pkg::MODE_W-1:0] in_mode,
  input  logic [rrf_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic [rrf_pkg::REQ_W-1:0]  in_read_count,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output rrf_pkg::cmd_t              cmd
);

  import rrf_pkg::*;

  cmd_t       dec;
  cmd_t       q_r [2];
  logic       q_wr_r, q_wr_nxt;
  logic       q_rd_r, q_rd_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       push, pop;

  always_comb begin
    dec.rx_byte = in_rx_byte;
    dec.req     = (in_read_count > REQ_W'(BURST_MAX)) ? REQ_W'(BURST_MAX) : in_read_count;
    unique case (in_mode)
      MODE_PUSH:  dec.op = OP_PUSH;
      MODE_POP:   dec.op = OP_POP;
      MODE_BURST: dec.op = OP_BURST;
      MODE_FLUSH: dec.op = OP_FLUSH;
      default:    dec.op = OP_QUERY;   // query and unused modes
    endcase
  end

  assign in_ready  = (q_cnt_r != 2'd2);
  assign cmd_valid = (q_cnt_r != 2'd0);
  assign cmd       = q_r[q_rd_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    q_wr_nxt  = push ? ~q_wr_r : q_wr_r;
    q_rd_nxt  = pop ? ~q_rd_r : q_rd_r;
    q_cnt_nxt = q_cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      q_wr_r  <= q_wr_nxt;
      q_rd_r  <= q_rd_nxt;
      q_cnt_r <= q_cnt_nxt;
    end
    if (push) begin
      q_r[q_wr_r] <= dec;
    end
  end

endmodule

### hdl/rrf_back.sv
// ----------------------------------------------------------------------------
// rrf_back
// Executor: owns the pointers, fill count and byte store, runs one queued
// command at a time and holds each result beat in an output register.
// ----------------------------------------------------------------------------
module rrf_back #(
  parameter int DEPTH = rrf_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  rrf_pkg::cmd_t               cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rrf_pkg::BYTE_W-1:0]  out_data_byte,
  output logic                        out_byte_valid,
  output logic [rrf_pkg::REQ_W-1:0]   out_granted_count,
  output logic [rrf_pkg::STAT_W-1:0]  out_status,
  output logic [rrf_pkg::LEVEL_W-1:0] out_fill_level,
  output logic                        out_last
);

  import rrf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int GW = (CW > REQ_W) ? CW : REQ_W;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_OUT} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [REQ_W-1:0]  rem_r, rem_nxt;
  logic [REQ_W-1:0]  grant_r, grant_nxt;
  logic              ovld_r, ovld_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              bv_r, bv_nxt;
  logic [REQ_W-1:0]  gcnt_r, gcnt_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              last_r, last_nxt;

  logic              we, re;
  logic [BYTE_W-1:0] rdata;
  logic [GW-1:0]     cnt_g, req_g;
  logic [REQ_W-1:0]  grant;
  logic [CW+8:0]     lvl_ext;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  rrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wp_r),
    .wdata (cmd.rx_byte),
    .re    (re),
    .raddr (rp_r),
    .rdata (rdata)
  );

  assign cnt_g = GW'(cnt_r);
  assign req_g = GW'(cmd.req);
  assign grant = (cnt_g < req_g) ? cnt_g[REQ_W-1:0] : cmd.req;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    rem_nxt   = rem_r;
    grant_nxt = grant_r;
    ovld_nxt  = ovld_r;
    data_nxt  = data_r;
    bv_nxt    = bv_r;
    gcnt_nxt  = gcnt_r;
    stat_nxt  = stat_r;
    last_nxt  = last_r;
    we        = 1'b0;
    re        = 1'b0;
    cmd_ready = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          // single-beat answer by default
          data_nxt  = '0;
          bv_nxt    = 1'b0;
          gcnt_nxt  = '0;
          stat_nxt  = ST_OK;
          last_nxt  = 1'b1;
          ovld_nxt  = 1'b1;
          state_nxt = S_OUT;
          unique case (cmd.op)
            OP_PUSH: begin
              if (cnt_r < CW'(DEPTH)) begin
                we      = 1'b1;
                wp_nxt  = ptr_inc(wp_r);
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                stat_nxt = ST_FULL;
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else begin
                re        = 1'b1;
                rp_nxt    = ptr_inc(rp_r);
                cnt_nxt   = cnt_r - 1'b1;
                grant_nxt = '0;
                rem_nxt   = '0;
                ovld_nxt  = 1'b0;
                state_nxt = S_RD;
              end
            end
            OP_BURST: begin
              if (cnt_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else if (cmd.req != '0) begin
                re        = 1'b1;
                rp_nxt    = ptr_inc(rp_r);
                cnt_nxt   = cnt_r - CW'(grant);
                grant_nxt = grant;
                rem_nxt   = grant - 1'b1;
                ovld_nxt  = 1'b0;
                state_nxt = S_RD;
              end
            end
            OP_FLUSH: begin
              rp_nxt  = wp_r;
              cnt_nxt = '0;
            end
            default: ;   // query: report only
          endcase
        end
      end
      S_RD: begin
        data_nxt  = rdata;
        bv_nxt    = 1'b1;
        gcnt_nxt  = grant_r;
        stat_nxt  = ST_OK;
        last_nxt  = (rem_r == '0);
        ovld_nxt  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          ovld_nxt = 1'b0;
          if (rem_r != '0) begin
            re        = 1'b1;
            rp_nxt    = ptr_inc(rp_r);
            rem_nxt   = rem_r - 1'b1;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rp_r    <= '0;
      wp_r    <= '0;
      rem_r   <= '0;
      grant_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      rem_r   <= rem_nxt;
      grant_r <= grant_nxt;
      ovld_r  <= ovld_nxt;
    end
    data_r <= data_nxt;
    bv_r   <= bv_nxt;
    gcnt_r <= gcnt_nxt;
    stat_r <= stat_nxt;
    last_r <= last_nxt;
  end

  // count is stable for every beat of a command and already final
  assign lvl_ext = {9'b0, cnt_r};

  assign out_valid         = ovld_r;
  assign out_data_byte     = data_r;
  assign out_byte_valid    = bv_r;
  assign out_granted_count = gcnt_r;
  assign out_status        = stat_r;
  assign out_fill_level    = lvl_ext[LEVEL_W-1:0];
  assign out_last          = last_r;

endmodule

### hdl/receive_ring_fifo_top.sv
// ----------------------------------------------------------------------------
// receive_ring_fifo_top
// Byte ring FIFO for received data: push (drop when full), pop, burst read,
// flush and level query.
//
//   channel  | ports                                        | direction
//   ---------+----------------------------------------------+----------
//   command  | in_valid/in_ready, mode, rx_byte, read_count | in
//   result   | out_valid/out_ready, data_byte, byte_valid,  | out
//            | granted_count, status, fill_level, last      |
//
// In the executor, push, flush, query and any command that moves no byte
// go straight to the output register; a pop or a burst reads each byte from
// the registered store port and then presents it, one byte at a time. A
// two-entry command queue lets the input side keep taking beats, until it is
// full, while a result waits on out_ready.
// Reset clears pointers, count and control; the byte store is not cleared.
// ----------------------------------------------------------------------------
module receive_ring_fifo_top #(
  parameter int DEPTH     = rrf_pkg::DEPTH_DEF,
  parameter int BURST_MAX = rrf_pkg::BURST_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rrf_pkg::MODE_W-1:0]  in_mode,
  input  logic [rrf_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic [rrf_pkg::REQ_W-1:0]   in_read_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rrf_pkg::BYTE_W-1:0]  out_data_byte,
  output logic                        out_byte_valid,
  output logic [rrf_pkg::REQ_W-1:0]   out_granted_count,
  output logic [rrf_pkg::STAT_W-1:0]  out_status,
  output logic [rrf_pkg::LEVEL_W-1:0] out_fill_level,
  output logic                        out_last
);

  import rrf_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  rrf_front #(
    .BURST_MAX (BURST_MAX)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_rx_byte    (in_rx_byte),
    .in_read_count (in_read_count),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  rrf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_byte_valid    (out_byte_valid),
    .out_granted_count (out_granted_count),
    .out_status        (out_status),
    .out_fill_level    (out_fill_level),
    .out_last          (out_last)
  );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for receive_ring_fifo_top. A scoreboard class keeps its
// own ring store, pointers and fill count, predicts the result beats of each
// accepted command, and checks every result beat in order. Stimulus runs a
// short directed set, then random phases: mixed traffic, a fill to full with
// dropped pushes, a drain by bursts, and mixed traffic again. Both sides idle
// at random; the receiver also holds off for a long stretch to back up input.
// ----------------------------------------------------------------------------
module testbench;
  import rrf_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int BURST_MAX  = BURST_MAX_DEF;
  localparam int RAND_ITEMS = 410;
  localparam int IDLE_PCT   = 36;
  localparam int HOLD_START = 300;
  localparam int HOLD_LEN   = 300;
  localparam int QUIET_LO   = 1200;
  localparam int QUIET_HI   = 1700;
  localparam int DRAIN_WAIT = 150;
  localparam logic [MODE_W-1:0] MODE_TOP = {MODE_W{1'b1}};

  typedef struct {
    logic [BYTE_W-1:0]  data;
    logic               valid;
    logic [REQ_W-1:0]   grant;
    logic [STAT_W-1:0]  status;
    logic [LEVEL_W-1:0] level;
    logic               is_last;
  } fifo_beat_t;

  class rx_fifo_scoreboard;
    logic [BYTE_W-1:0] ring [DEPTH];
    int rd_ptr;
    int wr_ptr;
    int held;
    fifo_beat_t beat_q[$];
    int errors;

    function new();
      rd_ptr = 0;
      wr_ptr = 0;
      held   = 0;
      errors = 0;
    endfunction

    function void add_beat(logic [BYTE_W-1:0] d, logic v, logic [REQ_W-1:0] g,
                           logic [STAT_W-1:0] s, logic l);
      fifo_beat_t b;
      b.data    = d;
      b.valid   = v;
      b.grant   = g;
      b.status  = s;
      b.level   = held[LEVEL_W-1:0];
      b.is_last = l;
      beat_q.push_back(b);
    endfunction

    // Predict the result beats of one accepted command.
    function void note_cmd(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] rx,
                           logic [REQ_W-1:0] req);
      int grant;
      logic [BYTE_W-1:0] d;
      case (m)
        MODE_PUSH: begin
          if (held < DEPTH) begin
            ring[wr_ptr] = rx;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            held++;
            add_beat('0, 1'b0, '0, ST_OK, 1'b1);
          end else begin
            add_beat('0, 1'b0, '0, ST_FULL, 1'b1);
          end
        end
        MODE_POP: begin
          if (held == 0) begin
            add_beat('0, 1'b0, '0, ST_EMPTY, 1'b1);
          end else begin
            d = ring[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
            held--;
            add_beat(d, 1'b1, '0, ST_OK, 1'b1);
          end
        end
        MODE_BURST: begin
          grant = (req > BURST_MAX) ? BURST_MAX : int'(req);
          if (held == 0) begin
            add_beat('0, 1'b0, '0, ST_EMPTY, 1'b1);
          end else begin
            if (grant > held) grant = held;
            if (grant == 0) begin
              add_beat('0, 1'b0, '0, ST_OK, 1'b1);
            end else begin
              // every beat of the burst reports the level after the burst
              held -= grant;
              for (int i = 0; i < grant; i++) begin
                d = ring[rd_ptr];
                rd_ptr = (rd_ptr + 1) % DEPTH;
                add_beat(d, 1'b1, REQ_W'(grant), ST_OK, (i == grant - 1));
              end
            end
          end
        end
        MODE_FLUSH: begin
          rd_ptr = wr_ptr;
          held   = 0;
          add_beat('0, 1'b0, '0, ST_OK, 1'b1);
        end
        default: begin
          add_beat('0, 1'b0, '0, ST_OK, 1'b1);
        end
      endcase
    endfunction

    function void check_beat(fifo_beat_t got);
      fifo_beat_t want;
      if (beat_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display(
            "[%0t] unexpected result beat: data=%02h valid=%0b grant=%0d st=%0d lvl=%0d last=%0b",
            $realtime, got.data, got.valid, got.grant, got.status, got.level,
            got.is_last);
        return;
      end
      want = beat_q.pop_front();
      if (got.data !== want.data || got.valid !== want.valid || got.grant !== want.grant ||
          got.status !== want.status || got.level !== want.level ||
          got.is_last !== want.is_last) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] result mismatch", $realtime);
          $display("  expected data=%02h valid=%0b grant=%0d st=%0d lvl=%0d last=%0b",
                   want.data, want.valid, want.grant, want.status, want.level,
                   want.is_last);
          $display("  actual   data=%02h valid=%0b grant=%0d st=%0d lvl=%0d last=%0b",
                   got.data, got.valid, got.grant, got.status, got.level, got.is_last);
        end
      end
    endfunction

    function void close_out();
      if (beat_q.size() != 0) begin
        errors++;
        $display("%0d expected result beats never arrived", beat_q.size());
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode = MODE_QUERY;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic [REQ_W-1:0]    in_read_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_data_byte;
  logic                out_byte_valid;
  logic [REQ_W-1:0]    out_granted_count;
  logic [STAT_W-1:0]   out_status;
  logic [LEVEL_W-1:0]  out_fill_level;
  logic                out_last;

  rx_fifo_scoreboard sb = new();
  int n_sent = 0;
  bit send_quiet = 1'b0;

  receive_ring_fifo_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_rx_byte        (in_rx_byte),
    .in_read_count     (in_read_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_byte_valid    (out_byte_valid),
    .out_granted_count (out_granted_count),
    .out_status        (out_status),
    .out_fill_level    (out_fill_level),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one command beat and hold it until accepted.
  task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] rx,
                          input logic [REQ_W-1:0] req);
    if (!send_quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid      <= 1'b0;
        in_mode       <= MODE_W'($urandom);
        in_rx_byte    <= BYTE_W'($urandom);
        in_read_count <= REQ_W'($urandom);
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_rx_byte    <= rx;
    in_read_count <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_cmd(m, rx, req);
    n_sent++;
  endtask

  function automatic logic [REQ_W-1:0] pick_count(input int big_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < big_pct) return REQ_W'($urandom_range(BURST_MAX / 2, (1 << REQ_W) - 1));
    if (r < big_pct + 15) return '0;
    return REQ_W'($urandom_range(1, 16));
  endfunction

  // phase 0 mixed, 1 fill, 2 drain
  task automatic send_random(input int phase);
    int r;
    logic [MODE_W-1:0] m;
    r = $urandom_range(0, 99);
    case (phase)
      1:       m = (r < 90) ? MODE_PUSH : (r < 95) ? MODE_POP : MODE_QUERY;
      2:       m = (r < 65) ? MODE_BURST : (r < 80) ? MODE_POP :
                   (r < 90) ? MODE_PUSH : MODE_QUERY;
      default: m = (r < 40) ? MODE_PUSH : (r < 55) ? MODE_POP : (r < 75) ? MODE_BURST :
                   (r < 80) ? MODE_FLUSH : (r < 90) ? MODE_QUERY : MODE_W'($urandom);
    endcase
    send_cmd(m, BYTE_W'($urandom), pick_count(phase == 2 ? 60 : 25));
  endtask

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
        out_ready <= 1'b0;
      else if (cyc >= QUIET_LO && cyc < QUIET_HI)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    fifo_beat_t got;
    if (rst_n && out_valid && out_ready) begin
      got.data    = out_data_byte;
      got.valid   = out_byte_valid;
      got.grant   = out_granted_count;
      got.status  = out_status;
      got.level   = out_fill_level;
      got.is_last = out_last;
      sb.check_beat(got);
    end
  end

  initial begin
    int n_rand;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, byte extremes, zero and oversized bursts, flush,
    // unused modes
    send_cmd(MODE_POP, 8'h00, '0);
    send_cmd(MODE_BURST, 8'h00, REQ_W'(10));
    send_cmd(MODE_QUERY, 8'hff, {REQ_W{1'b1}});
    send_cmd(MODE_PUSH, 8'h00, '0);
    send_cmd(MODE_PUSH, 8'hff, {REQ_W{1'b1}});
    send_cmd(MODE_PUSH, 8'ha5, '0);
    send_cmd(MODE_BURST, 8'h00, '0);
    send_cmd(MODE_POP, 8'h00, '0);
    send_cmd(MODE_BURST, 8'h00, {REQ_W{1'b1}});
    send_cmd(MODE_PUSH, 8'h5a, '0);
    send_cmd(MODE_PUSH, 8'h3c, '0);
    send_cmd(MODE_FLUSH, 8'h00, '0);
    send_cmd(MODE_POP, 8'h00, '0);
    send_cmd(MODE_BURST, 8'h00, REQ_W'(BURST_MAX));
    for (logic [MODE_W:0] m = MODE_QUERY + 1; m <= MODE_TOP; m++)
      send_cmd(m[MODE_W-1:0], BYTE_W'($urandom), REQ_W'($urandom));
    send_cmd(MODE_PUSH, 8'h81, '0);
    send_cmd(MODE_PUSH, 8'h7e, '0);
    send_cmd(MODE_BURST, 8'h00, REQ_W'(BURST_MAX + 1));
    send_cmd(MODE_FLUSH, 8'h00, '0);

    n_rand = 0;
    while (n_rand < 60) begin
      send_random(0);
      n_rand++;
    end
    // fill to full, with a stretch of back-to-back beats
    while (sb.held < DEPTH) begin
      send_quiet = (n_sent >= 150 && n_sent < 230);
      send_random(1);
      n_rand++;
    end
    send_quiet = 1'b0;
    repeat (6) begin
      send_cmd(MODE_PUSH, BYTE_W'($urandom), REQ_W'($urandom));
      n_rand++;
    end
    while (sb.held > 0) begin
      send_random(2);
      n_rand++;
    end
    while (n_rand < RAND_ITEMS) begin
      send_random(0);
      n_rand++;
    end

    in_valid <= 1'b0;
    while (sb.beat_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the block");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
